FILE: src/osr_pkg.sv
// Package for the ODE shooting residual block.
// Holds fixed-point widths, limits, counter codes and the sequencer state type.
// Used by every module in src; depends on nothing.
`default_nettype none

package osr_pkg;

  localparam int FRAC_BITS        = 24;
  localparam int MAX_LOG2_STEPS   = 12;
  localparam int LOG2_W           = 4;
  localparam int K_W              = MAX_LOG2_STEPS + 1;
  localparam int G_W              = 40;
  localparam int C_W              = 33;
  localparam int NUM_W            = 53;
  localparam int DIVIDEND_W       = 40;
  localparam int ACC_W            = 52;
  localparam int MUL_A_W          = 40;
  localparam int MUL_B_W          = 33;
  localparam int MUL_P_W          = MUL_A_W + MUL_B_W;
  localparam int MUL_SPLIT        = 20;
  localparam int RADICAND_W       = 64;
  localparam int ROOT_W           = 32;

  localparam logic [LOG2_W-1:0] LOG2_STEPS_RESET = 4'd11;
  localparam logic [LOG2_W-1:0] LOG2_STEPS_MIN   = 4'd1;
  localparam logic [LOG2_W-1:0] LOG2_STEPS_MAX   = LOG2_W'(MAX_LOG2_STEPS);

  localparam logic signed [ACC_W-1:0] G_MAX = ACC_W'(64'sd549755813887);
  localparam logic signed [ACC_W-1:0] G_MIN = -ACC_W'(64'sd549755813888);

  // Coefficient being divided out during a recurrence step.
  localparam logic [1:0] COEF_C1 = 2'd0;
  localparam logic [1:0] COEF_C2 = 2'd1;
  localparam logic [1:0] COEF_C3 = 2'd2;

  // Product index: three products build the real part, three the imaginary part.
  localparam logic [2:0] PROD_RE_LAST = 3'd2;
  localparam logic [2:0] PROD_IM_LAST = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_PREP,
    ST_DIV_LOAD,
    ST_DIV_WAIT,
    ST_MUL_LOAD,
    ST_MUL_WAIT,
    ST_MAG,
    ST_SQ_LOAD,
    ST_SQ_WAIT,
    ST_ROOT_LOAD,
    ST_ROOT_WAIT,
    ST_OUT
  } osr_state_t;

endpackage

`default_nettype wire

FILE: src/osr_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Divides a 40-bit dividend by a 13-bit divisor; depends on osr_pkg.
`default_nettype none

module osr_divider (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [osr_pkg::DIVIDEND_W-1:0]    dividend,
  input  wire logic [osr_pkg::K_W-1:0]           divisor,
  output logic                                   done,
  output logic [osr_pkg::DIVIDEND_W-1:0]         quotient
);

  logic                              busy;
  logic [5:0]                        cnt;
  logic [osr_pkg::DIVIDEND_W-1:0]    q;
  logic [osr_pkg::K_W-1:0]           rem;
  logic [osr_pkg::K_W-1:0]           d;
  logic [osr_pkg::K_W:0]             rem_sh;

  assign rem_sh   = {rem, q[osr_pkg::DIVIDEND_W-1]};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(osr_pkg::DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      d   <= divisor;
    end else if (busy) begin
      if (rem_sh >= {1'b0, d}) begin
        rem <= osr_pkg::K_W'(rem_sh - {1'b0, d});
        q   <= {q[osr_pkg::DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[osr_pkg::K_W-1:0];
        q   <= {q[osr_pkg::DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/osr_multiplier.sv
// Unsigned 40 x 33 multiplier built from one 20 x 33 array used twice.
// Registers the low partial product, then adds the high; uses osr_pkg.
`default_nettype none

module osr_multiplier (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [osr_pkg::MUL_A_W-1:0]    a,
  input  wire logic [osr_pkg::MUL_B_W-1:0]    b,
  output logic                                done,
  output logic [osr_pkg::MUL_P_W-1:0]         product
);

  localparam int PP_W = osr_pkg::MUL_SPLIT + osr_pkg::MUL_B_W;

  logic                            busy;
  logic                            hi_phase;
  logic [osr_pkg::MUL_A_W-1:0]     a_r;
  logic [osr_pkg::MUL_B_W-1:0]     b_r;
  logic [PP_W-1:0]                 part;
  logic [osr_pkg::MUL_SPLIT-1:0]   opnd;
  logic [PP_W-1:0]                 pp;

  assign opnd = hi_phase ? a_r[osr_pkg::MUL_A_W-1:osr_pkg::MUL_SPLIT]
                         : a_r[osr_pkg::MUL_SPLIT-1:0];
  assign pp   = PP_W'(opnd) * PP_W'(b_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      hi_phase <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        hi_phase <= 1'b0;
      end else if (busy) begin
        hi_phase <= 1'b1;
        if (hi_phase) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (busy) begin
      if (!hi_phase) begin
        part <= pp;
      end else begin
        product <= {pp, {osr_pkg::MUL_SPLIT{1'b0}}} + osr_pkg::MUL_P_W'(part);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/osr_isqrt.sv
// Bitwise integer square root of a 64-bit value, one root bit per cycle.
// Gives floor(sqrt(x)) after 32 iterations; depends on osr_pkg.
`default_nettype none

module osr_isqrt (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [osr_pkg::RADICAND_W-1:0]    radicand,
  output logic                                   done,
  output logic [osr_pkg::ROOT_W-1:0]             root
);

  localparam int REM_W = osr_pkg::ROOT_W + 4;

  logic                              busy;
  logic [4:0]                        cnt;
  logic [osr_pkg::RADICAND_W-1:0]    s;
  logic [REM_W-1:0]                  rem;
  logic [osr_pkg::ROOT_W-1:0]        root_sh;
  logic [REM_W-1:0]                  rem_sh;
  logic [REM_W-1:0]                  trial;

  assign root_sh = {root[osr_pkg::ROOT_W-2:0], 1'b0};
  assign rem_sh  = {rem[REM_W-3:0], s[osr_pkg::RADICAND_W-1 -: 2]};
  assign trial   = {3'b000, root_sh, 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(osr_pkg::ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      s <= {s[osr_pkg::RADICAND_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= root_sh | osr_pkg::ROOT_W'(1);
      end else begin
        rem  <= rem_sh;
        root <= root_sh;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/ode_shooting_residual_top.sv
// Top level of the ODE shooting residual block: sequencer and fixed-point datapath.
// Instantiates osr_divider, osr_multiplier and osr_isqrt; depends on osr_pkg.
//
// One request on the slave channel carries kz, the real and the imaginary part
// of a frequency guess, each signed Q8.24. The block runs the three-term complex
// recurrence over N = 2^log2_steps points and returns |g| at s = 1 as unsigned
// Q8.24 on the master channel, with tuser set when any value saturated.
// log2_steps is written through cfg_wr_en and cfg_wr_data; the user must write it
// only while the block is idle, which the block itself does not enforce. Values
// below 1 or above 12 are clamped when a request is taken. Each recurrence step
// divides out three coefficients on the shared serial divider and forms six
// products on the shared multiplier; the divider takes most of the run time.
// A new request can be taken only once the previous result has gone to the
// output register.
// s_tready is high only while the sequencer is idle. A finished result waits in
// the output register; a new request is taken meanwhile, and its result is held
// back until the receiver has taken the previous one.
// Reset clears the sequencer and the output valid and sets log2_steps to 11.
`default_nettype none

module ode_shooting_residual_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_wr_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // wavenumber [31:0], freq_real [63:32], freq_imag [95:64]
  input  wire logic [95:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // residual_magnitude [31:0]
  output logic [31:0]      m_tdata,
  // saturated [0]
  output logic             m_tuser
);

  localparam int G_W   = osr_pkg::G_W;
  localparam int ACC_W = osr_pkg::ACC_W;
  localparam int NUM_W = osr_pkg::NUM_W;
  localparam int K_W   = osr_pkg::K_W;
  localparam int C_W   = osr_pkg::C_W;

  osr_pkg::osr_state_t state, state_next;

  logic [3:0]                log2_steps;
  logic [3:0]                lg;
  logic signed [32:0]        ar;
  logic signed [32:0]        ai;
  logic signed [31:0]        bi;
  logic [K_W-1:0]            k;
  logic [1:0]                ci;
  logic [2:0]                j;
  logic signed [G_W-1:0]     ppr, ppi, pr, pi, gre;
  logic [C_W-1:0]            c1_mag, c2_mag, c3_mag;
  logic                      c1_neg, c2_neg, c3_neg;
  logic signed [NUM_W-1:0]   num;
  logic                      mul_neg;
  logic signed [ACC_W-1:0]   acc;
  logic [64:0]               ssum;
  logic                      flag;
  logic [31:0]               res;

  logic                      div_start, div_done;
  logic [osr_pkg::DIVIDEND_W-1:0] div_dividend, div_q;
  logic                      mul_start, mul_done;
  logic [osr_pkg::MUL_A_W-1:0] mul_a;
  logic [osr_pkg::MUL_B_W-1:0] mul_b;
  logic [osr_pkg::MUL_P_W-1:0] mul_p;
  logic                      root_start, root_done;
  logic [31:0]               root;

  logic [K_W-1:0]            last_k;
  logic [K_W-1:0]            kp1;
  logic                      in_fire;
  logic                      out_free;

  assign last_k   = (K_W'(1) << lg) - K_W'(1);
  assign kp1      = k + K_W'(1);
  assign s_tready = (state == osr_pkg::ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Start values: pr = 1 - ar*h/8, pi = -ai*h/8, rounded to nearest.
  logic [32:0]           ar_mag, ai_mag;
  logic [33:0]           ar_rnd, ai_rnd;
  logic signed [G_W-1:0] ar_q, ai_q, pr0, pi0;

  always_comb begin
    ar_mag = ar[32] ? 33'(-ar) : 33'(ar);
    ai_mag = ai[32] ? 33'(-ai) : 33'(ai);
    ar_rnd = ({1'b0, ar_mag} + (34'd1 << (lg + 4'd2))) >> (lg + 4'd3);
    ai_rnd = ({1'b0, ai_mag} + (34'd1 << (lg + 4'd2))) >> (lg + 4'd3);
    ar_q   = G_W'(ar_rnd);
    ai_q   = G_W'(ai_rnd);
    pr0    = ar[32] ? (G_W'(1 << osr_pkg::FRAC_BITS) + ar_q)
                    : (G_W'(1 << osr_pkg::FRAC_BITS) - ar_q);
    pi0    = ai[32] ? ai_q : -ai_q;
  end

  // Numerator of the coefficient being prepared.
  logic signed [45:0]      bik;
  logic signed [NUM_W-1:0] num_c;

  always_comb begin
    bik = bi * $signed({1'b0, k});
    case (ci)
      osr_pkg::COEF_C1: num_c = $signed({16'd0, k - K_W'(1), 24'd0});
      osr_pkg::COEF_C2: num_c = $signed(NUM_W'(k) << (6'(lg) + 6'd27))
                                - {{20{ar[32]}}, ar};
      default:          num_c = {{7{bik[45]}}, bik}
                                + ({{20{ai[32]}}, ai} <<< lg);
    endcase
  end

  // Rounded quotient: (|num| + den/2) / den with den = (k+1) * 2^sh.
  logic [NUM_W-1:0] num_mag, half, rnd_x;
  logic [4:0]       sh;

  always_comb begin
    num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    case (ci)
      osr_pkg::COEF_C1: begin
        half = NUM_W'(kp1 >> 1);
        sh   = 5'd0;
      end
      osr_pkg::COEF_C2: begin
        half = NUM_W'(kp1) << (lg + 4'd1);
        sh   = 5'(lg) + 5'd2;
      end
      default: begin
        half = NUM_W'(kp1) << ({lg, 1'b0} + 5'd1);
        sh   = {lg, 1'b0} + 5'd2;
      end
    endcase
    rnd_x        = num_mag + half;
    div_dividend = osr_pkg::DIVIDEND_W'(rnd_x >> sh);
  end

  // Operands of the current product.
  logic [C_W-1:0]        sel_cm;
  logic                  sel_cn;
  logic signed [G_W-1:0] sel_g;
  logic [G_W-1:0]        sel_gmag;
  logic [G_W-1:0]        ur, ui;

  always_comb begin
    case (j)
      3'd0:    begin sel_cm = c1_mag; sel_cn = c1_neg;  sel_g = ppr; end
      3'd1:    begin sel_cm = c2_mag; sel_cn = c2_neg;  sel_g = pr;  end
      3'd2:    begin sel_cm = c3_mag; sel_cn = c3_neg;  sel_g = pi;  end
      3'd3:    begin sel_cm = c1_mag; sel_cn = c1_neg;  sel_g = ppi; end
      3'd4:    begin sel_cm = c2_mag; sel_cn = c2_neg;  sel_g = pi;  end
      default: begin sel_cm = c3_mag; sel_cn = !c3_neg; sel_g = pr;  end
    endcase
    sel_gmag = sel_g[G_W-1] ? G_W'(-sel_g) : G_W'(sel_g);
    ur       = pr[G_W-1] ? G_W'(-pr) : G_W'(pr);
    ui       = pi[G_W-1] ? G_W'(-pi) : G_W'(pi);
  end

  // Rounded product term and running sum.
  logic [48:0]             prod_r;
  logic signed [ACC_W-1:0] term, sum;
  logic signed [G_W-1:0]   sum_sat;
  logic                    sum_ovf;

  always_comb begin
    prod_r  = 49'((mul_p + osr_pkg::MUL_P_W'(1 << (osr_pkg::FRAC_BITS - 1)))
                  >> osr_pkg::FRAC_BITS);
    term    = mul_neg ? -$signed(ACC_W'(prod_r)) : $signed(ACC_W'(prod_r));
    sum     = acc + term;
    sum_ovf = (sum > osr_pkg::G_MAX) || (sum < osr_pkg::G_MIN);
    if (sum > osr_pkg::G_MAX) begin
      sum_sat = G_W'(osr_pkg::G_MAX);
    end else if (sum < osr_pkg::G_MIN) begin
      sum_sat = G_W'(osr_pkg::G_MIN);
    end else begin
      sum_sat = G_W'(sum);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      osr_pkg::ST_IDLE:      if (in_fire) state_next = osr_pkg::ST_INIT;
      osr_pkg::ST_INIT:      state_next = osr_pkg::ST_PREP;
      osr_pkg::ST_PREP:      state_next = osr_pkg::ST_DIV_LOAD;
      osr_pkg::ST_DIV_LOAD:  state_next = osr_pkg::ST_DIV_WAIT;
      osr_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = (ci == osr_pkg::COEF_C3) ? osr_pkg::ST_MUL_LOAD : osr_pkg::ST_PREP;
        end
      end
      osr_pkg::ST_MUL_LOAD:  state_next = osr_pkg::ST_MUL_WAIT;
      osr_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          if (j != osr_pkg::PROD_IM_LAST) begin
            state_next = osr_pkg::ST_MUL_LOAD;
          end else if (k == last_k) begin
            state_next = osr_pkg::ST_MAG;
          end else begin
            state_next = osr_pkg::ST_PREP;
          end
        end
      end
      osr_pkg::ST_MAG: begin
        state_next = (ur[G_W-1:32] != '0 || ui[G_W-1:32] != '0) ? osr_pkg::ST_OUT
                                                                : osr_pkg::ST_SQ_LOAD;
      end
      osr_pkg::ST_SQ_LOAD:   state_next = osr_pkg::ST_SQ_WAIT;
      osr_pkg::ST_SQ_WAIT: begin
        if (mul_done) begin
          state_next = (j == 3'd0) ? osr_pkg::ST_SQ_LOAD : osr_pkg::ST_ROOT_LOAD;
        end
      end
      osr_pkg::ST_ROOT_LOAD: state_next = ssum[64] ? osr_pkg::ST_OUT : osr_pkg::ST_ROOT_WAIT;
      osr_pkg::ST_ROOT_WAIT: if (root_done) state_next = osr_pkg::ST_OUT;
      osr_pkg::ST_OUT:       if (out_free) state_next = osr_pkg::ST_IDLE;
      default:               state_next = osr_pkg::ST_IDLE;
    endcase
  end

  // Unit requests and operands.
  always_comb begin
    div_start  = (state == osr_pkg::ST_DIV_LOAD);
    mul_start  = (state == osr_pkg::ST_MUL_LOAD) || (state == osr_pkg::ST_SQ_LOAD);
    root_start = (state == osr_pkg::ST_ROOT_LOAD) && !ssum[64];
    if (state == osr_pkg::ST_SQ_LOAD) begin
      mul_a = (j == 3'd0) ? ur : ui;
      mul_b = (j == 3'd0) ? C_W'(ur[31:0]) : C_W'(ui[31:0]);
    end else begin
      mul_a = sel_gmag;
      mul_b = sel_cm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= osr_pkg::ST_IDLE;
      log2_steps <= osr_pkg::LOG2_STEPS_RESET;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        log2_steps <= cfg_wr_data;
      end
      if (state == osr_pkg::ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == osr_pkg::ST_OUT && out_free) begin
      m_tdata <= res;
      m_tuser <= flag;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      osr_pkg::ST_IDLE: begin
        if (in_fire) begin
          ar <= -{s_tdata[95], s_tdata[95:64]};
          ai <= {s_tdata[63], s_tdata[63:32]} - {s_tdata[31], s_tdata[31:0]};
          bi <= s_tdata[31:0];
          if (log2_steps < osr_pkg::LOG2_STEPS_MIN) begin
            lg <= osr_pkg::LOG2_STEPS_MIN;
          end else if (log2_steps > osr_pkg::LOG2_STEPS_MAX) begin
            lg <= osr_pkg::LOG2_STEPS_MAX;
          end else begin
            lg <= log2_steps;
          end
        end
      end
      osr_pkg::ST_INIT: begin
        ppr  <= G_W'(1 << osr_pkg::FRAC_BITS);
        ppi  <= '0;
        pr   <= pr0;
        pi   <= pi0;
        k    <= K_W'(1);
        ci   <= osr_pkg::COEF_C1;
        flag <= 1'b0;
      end
      osr_pkg::ST_PREP: begin
        num <= num_c;
      end
      osr_pkg::ST_DIV_LOAD: begin
      end
      osr_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          case (ci)
            osr_pkg::COEF_C1: begin
              c1_mag <= div_q[C_W-1:0];
              c1_neg <= 1'b1;
            end
            osr_pkg::COEF_C2: begin
              c2_mag <= div_q[C_W-1:0];
              c2_neg <= num[NUM_W-1];
            end
            default: begin
              c3_mag <= div_q[C_W-1:0];
              c3_neg <= num[NUM_W-1];
            end
          endcase
          ci  <= ci + 2'd1;
          j   <= '0;
          acc <= '0;
        end
      end
      osr_pkg::ST_MUL_LOAD: begin
        mul_neg <= sel_cn ^ sel_g[G_W-1];
      end
      osr_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          j <= j + 3'd1;
          if (j == osr_pkg::PROD_RE_LAST) begin
            gre  <= sum_sat;
            acc  <= '0;
            flag <= flag | sum_ovf;
          end else if (j == osr_pkg::PROD_IM_LAST) begin
            ppr  <= pr;
            ppi  <= pi;
            pr   <= gre;
            pi   <= sum_sat;
            flag <= flag | sum_ovf;
            k    <= kp1;
            ci   <= osr_pkg::COEF_C1;
          end else begin
            acc <= sum;
          end
        end
      end
      osr_pkg::ST_MAG: begin
        j    <= '0;
        ssum <= '0;
        if (ur[G_W-1:32] != '0 || ui[G_W-1:32] != '0) begin
          res  <= '1;
          flag <= 1'b1;
        end
      end
      osr_pkg::ST_SQ_LOAD: begin
      end
      osr_pkg::ST_SQ_WAIT: begin
        if (mul_done) begin
          ssum <= ssum + 65'(mul_p);
          j    <= j + 3'd1;
        end
      end
      osr_pkg::ST_ROOT_LOAD: begin
        if (ssum[64]) begin
          res  <= '1;
          flag <= 1'b1;
        end
      end
      osr_pkg::ST_ROOT_WAIT: begin
        if (root_done) begin
          res <= root;
        end
      end
      osr_pkg::ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  osr_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (kp1),
    .done     (div_done),
    .quotient (div_q)
  );

  osr_multiplier u_multiplier (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  osr_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (ssum[63:0]),
    .done     (root_done),
    .root     (root)
  );

`ifndef SYNTHESIS
  a_one_request_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while a computation was running");

  a_steps_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != osr_pkg::ST_IDLE && state != osr_pkg::ST_INIT) |->
      (lg >= osr_pkg::LOG2_STEPS_MIN && lg <= osr_pkg::LOG2_STEPS_MAX &&
       k <= last_k + K_W'(1)))
    else $error("step counter or step count out of range");

  a_single_unit_busy: assert property (@(posedge clk) disable iff (rst)
    $countones({div_start, mul_start, root_start}) <= 1)
    else $error("two shared units started in the same cycle");
`endif

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for ode_shooting_residual_top: directed, sweep, backpressure and random requests.
// Predicts |g| and the saturation flag with its own fixed-point recurrence model.
// Depends on src/osr_pkg.sv and src/ode_shooting_residual_top.sv.
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic [31:0] magnitude;
    logic        saturated;
  } residual_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tuser;

  residual_t   residual_q[$];
  logic [3:0]  steps_reg;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          recv_hold;
  int          n_errors;
  int          n_sent;
  int          n_checked;

  ode_shooting_residual_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("%0t timeout", $time);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint sat_g(longint v, inout bit flag);
    if (v > 64'sd549755813887) begin
      flag = 1'b1;
      return 64'sd549755813887;
    end
    if (v < -64'sd549755813888) begin
      flag = 1'b1;
      return -64'sd549755813888;
    end
    return v;
  endfunction

  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint round_mul(longint x, longint y);
    longint unsigned ux;
    longint unsigned uy;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned r;
    ux = (x < 0) ? -x : x;
    uy = (y < 0) ? -y : y;
    hi = ux * (uy >> 20);
    lo = ux * (uy & 64'hFFFFF) + (64'd1 << 23);
    r = (hi >> 4) + ((((hi & 64'd15) << 20) + lo) >> 24);
    return ((x < 0) != (y < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned bit_sqrt(longint unsigned s);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned trial;
    rem = 0;
    root = 0;
    for (int i = 0; i < 32; i++) begin
      root = root << 1;
      rem = (rem << 2) | (s >> 62);
      s = s << 2;
      trial = (root << 1) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 64'd1;
      end
    end
    return root;
  endfunction

  function automatic residual_t shoot_residual(logic [95:0] req, logic [3:0] lg_raw);
    longint kz;
    longint ar;
    longint ai;
    longint ppr;
    longint ppi;
    longint pr;
    longint pi;
    longint gr;
    longint gi;
    longint c1;
    longint c2;
    longint c3;
    longint num;
    longint unsigned den4;
    longint unsigned ur;
    longint unsigned ui;
    longint unsigned sr;
    longint unsigned sum;
    int lg;
    int n;
    bit flag;
    residual_t r;
    kz = longint'($signed(req[31:0]));
    ar = -longint'($signed(req[95:64]));
    ai = longint'($signed(req[63:32])) - kz;
    lg = int'(lg_raw);
    if (lg < 1) lg = 1;
    if (lg > osr_pkg::MAX_LOG2_STEPS) lg = osr_pkg::MAX_LOG2_STEPS;
    n = 1 << lg;
    flag = 1'b0;
    ppr = 64'sd1 << 24;
    ppi = 0;
    pr = sat_g(ppr - round_div(ar, 64'd1 << (lg + 3)), flag);
    pi = sat_g(-round_div(ai, 64'd1 << (lg + 3)), flag);
    gr = pr;
    gi = pi;
    for (int k = 1; k < n; k++) begin
      den4 = 4 * (k + 1);
      c1 = -round_div(longint'(k - 1) << 24, k + 1);
      num = (longint'(8 * k) << (24 + lg)) - ar;
      c2 = round_div(num, den4 << lg);
      num = kz * k + (ai <<< lg);
      c3 = round_div(num, den4 << (2 * lg));
      gr = sat_g(round_mul(c1, ppr) + round_mul(c2, pr) + round_mul(c3, pi), flag);
      gi = sat_g(round_mul(c1, ppi) + round_mul(c2, pi) - round_mul(c3, pr), flag);
      ppr = pr;
      ppi = pi;
      pr = gr;
      pi = gi;
    end
    ur = (gr < 0) ? -gr : gr;
    ui = (gi < 0) ? -gi : gi;
    if (ur > 64'hFFFFFFFF || ui > 64'hFFFFFFFF) begin
      r.magnitude = 32'hFFFFFFFF;
      flag = 1'b1;
    end else begin
      sr = ur * ur;
      sum = sr + ui * ui;
      if (sum < sr) begin
        r.magnitude = 32'hFFFFFFFF;
        flag = 1'b1;
      end else begin
        r.magnitude = 32'(bit_sqrt(sum));
      end
    end
    r.saturated = flag;
    return r;
  endfunction

  // Receiver: random stalls, or a long hold-off while recv_hold counts down.
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    residual_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (residual_q.size() == 0) begin
        $display("%0t unexpected result: actual mag %h sat %b", $time, m_tdata, m_tuser);
        n_errors++;
      end else begin
        want = residual_q.pop_front();
        n_checked++;
        if (m_tdata !== want.magnitude) begin
          $display("%0t magnitude: expected %h actual %h", $time, want.magnitude, m_tdata);
          n_errors++;
        end
        if (m_tuser !== want.saturated) begin
          $display("%0t saturated: expected %b actual %b", $time, want.saturated, m_tuser);
          n_errors++;
        end
      end
    end
  end

  task automatic send_request(logic [31:0] kz, logic [31:0] fr, logic [31:0] fi);
    if ($urandom_range(99) < send_idle_pct) repeat ($urandom_range(1, 20)) @(negedge clk);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = {fi, fr, kz};
    do @(posedge clk); while (!s_tready);
    residual_q.push_back(shoot_residual({fi, fr, kz}, steps_reg));
    n_sent++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (residual_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_steps(logic [3:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    steps_reg = value;
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 32'h0FFFFFFF)) - 32'sh08000000);
    endcase
  endfunction

  task automatic test_directed();
    write_steps(4'd3);
    send_request(32'h0, 32'h0, 32'h0);
    send_request(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_request(32'h80000000, 32'h80000000, 32'h80000000);
    send_request(32'h7FFFFFFF, 32'h80000000, 32'h0);
    send_request(32'h0, 32'h0, 32'h80000000);
    send_request(32'h0, 32'h0, 32'h7FFFFFFF);
    send_request(32'h01000000, 32'h02000000, 32'hFF000000);
    send_request(32'hFFFFFFFF, 32'h00000001, 32'h00800000);
    send_request(32'hFE000000, 32'h03000000, 32'h00400000);
    send_request(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
  endtask

  task automatic test_steps_sweep();
    for (int lg = 0; lg <= 9; lg++) begin
      write_steps(4'(lg));
      send_request(rand_field(), rand_field(), rand_field());
      if (lg < 5) send_request(32'h00800000, 32'hFF400000, 32'h00200000);
    end
    write_steps(4'd12);
    write_steps(4'd15);
    send_request(32'h00100000, 32'h00200000, 32'hFFF00000);
  endtask

  task automatic test_backpressure();
    write_steps(4'd2);
    wait_drained();
    recv_hold = 3000;
    for (int i = 0; i < 4; i++) send_request(rand_field(), rand_field(), rand_field());
    wait_drained();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 8 == 0) write_steps(4'($urandom_range(1, 4)));
      send_request(rand_field(), rand_field(), rand_field());
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 4'd0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    recv_hold = 0;
    send_idle_pct = 10;
    recv_stall_pct = 80;
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    steps_reg = osr_pkg::LOG2_STEPS_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_steps_sweep();
    test_backpressure();
    test_random(24, 10, 80);
    test_random(23, 80, 10);
    test_random(23, 0, 0);
    wait_drained();
    repeat (200) @(posedge clk);
    $display("Sent %0d requests, checked %0d results, step counts 2 to 4096.", n_sent,
             n_checked);
    $display("Covered field extremes, clamped register values and output backpressure.");
    if (n_errors == 0 && residual_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
